// ----- src/lcm_pkg.sv -----
// ----------------------------------------------------------------------------
// lcm_pkg: shared definitions for the LC meter gated counter
// Widths, reset values, item and status codes, sequencer states and the
// small structs that pass between the gate counter, the divider and the core.
// ----------------------------------------------------------------------------
package lcm_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned GATE_W    = 8;
  localparam int unsigned SCALE_W   = 53;
  localparam int unsigned RANGE_W   = 32;
  localparam int unsigned READ_W    = 32;
  localparam int unsigned EDGE_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = SCALE_W;

  localparam logic [GATE_W-1:0]  GATE_TICKS_RST = 8'd62;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 53'd3497379064000000;
  localparam logic [RANGE_W-1:0] RANGE_RST      = 32'd1000000000;
  localparam logic [SCALE_W-1:0] RAW_SAT        = {SCALE_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_EDGE  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_ZERO_SET  = 2'd1,
    STATUS_RANGE_ERR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_TICKS = 2'd0,
    CFG_SCALE      = 2'd1,
    CFG_RANGE      = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_LAUNCH,
    S_DIVIDE,
    S_DIFF,
    S_EMIT
  } seq_state_e;

  // Event from the gate counter: the gate has just closed.
  typedef struct packed {
    logic close;
    logic zero;
  } gate_evt_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/lcm_gate.sv -----
// ----------------------------------------------------------------------------
// lcm_gate: measurement gate with tick and oscillator edge counters
// Opens on a start item, counts edges and ticks, closes on the last tick.
// ----------------------------------------------------------------------------
module lcm_gate import lcm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic                   zero_button_i,
  input  logic [GATE_W-1:0]      gate_ticks_i,
  output gate_evt_t              evt_o,
  output logic [COUNT_WIDTH-1:0] count_o
);

  logic                   open_q, open_d;
  logic [GATE_W-1:0]      tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] pulse_q, pulse_d;
  logic [GATE_W:0]        tick_inc;
  logic                   last_tick;

  // A gate length of zero behaves as one: the first tick closes.
  assign tick_inc  = {1'b0, tick_q} + {{GATE_W{1'b0}}, 1'b1};
  assign last_tick = tick_inc >= {1'b0, gate_ticks_i};

  always_comb begin
    open_d     = open_q;
    tick_d     = tick_q;
    pulse_d    = pulse_q;
    evt_o      = '0;
    evt_o.zero = zero_button_i;
    if (take_i) begin
      case (kind_i)
        KIND_START: begin
          open_d  = 1'b1;
          tick_d  = '0;
          pulse_d = '0;
        end
        KIND_TICK: begin
          if (open_q) begin
            if (last_tick) begin
              open_d      = 1'b0;
              evt_o.close = 1'b1;
            end else begin
              tick_d = tick_inc[GATE_W-1:0];
            end
          end
        end
        KIND_EDGE: begin
          if (open_q) begin
            pulse_d = pulse_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      tick_q  <= '0;
      pulse_q <= '0;
    end else begin
      open_q  <= open_d;
      tick_q  <= tick_d;
      pulse_q <= pulse_d;
    end
  end

  assign count_o = pulse_q;

endmodule

// ----- src/lcm_divider.sv -----
// ----------------------------------------------------------------------------
// lcm_divider: restoring divider, one quotient bit per cycle
// Shifts in the quotient bits after a start; done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
module lcm_divider import lcm_pkg::*; #(
  parameter int unsigned NUM_W = SCALE_W,
  parameter int unsigned DEN_W = 2 * COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_status_t      status_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W+1:0]  sub;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, den_q};
  assign fits  = ~sub[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - {{(STEP_W-1){1'b0}}, 1'b1};
        if (step_q == {{(STEP_W-1){1'b0}}, 1'b1}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

// ----- src/lc_meter_gated_counter_core.sv -----
// ----------------------------------------------------------------------------
// lc_meter_gated_counter_core: gated frequency counter with LC reading
// Counts oscillator edges over a gate of timebase ticks, then works out
// floor(scale / count^2) and reports it against a stored zero offset.
// ----------------------------------------------------------------------------
// Start, tick and edge items are taken one per cycle while the input is not
// stalled, so edges arriving at the full clock rate are all counted.
// The tick that closes the gate starts the reading calculation, and the input
// is stalled until that result has been placed in the output register: the
// count is squared, a restoring division runs in the subtract-and-compare
// unit unless the count is zero, then the offset difference and range check,
// plus any time spent waiting for the previous result to be taken. The
// output register lets new items be accepted while a finished result waits
// for its transfer. Configuration is written through a simple write port and
// takes effect at once; it should only be changed while no calculation runs.
// ----------------------------------------------------------------------------
module lc_meter_gated_counter_core import lcm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic                 zero_button_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [READ_W-1:0]    reading_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [EDGE_W-1:0]    edge_count_o
);

  localparam int unsigned SQ_W = 2 * COUNT_WIDTH;

  // Configuration registers.
  logic [GATE_W-1:0]  gate_ticks_q;
  logic [SCALE_W-1:0] scale_q;
  logic [RANGE_W-1:0] range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q <= GATE_TICKS_RST;
      scale_q      <= SCALE_RST;
      range_q      <= RANGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GATE_TICKS: gate_ticks_q <= cfg_wdata_i[GATE_W-1:0];
        CFG_SCALE:      scale_q      <= cfg_wdata_i[SCALE_W-1:0];
        CFG_RANGE:      range_q      <= cfg_wdata_i[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Gate and counters. The edge count stays put once the gate has closed,
  // since no start can be taken until the calculation is over.
  logic                   take;
  gate_evt_t              gate_evt;
  logic [COUNT_WIDTH-1:0] count;
  logic                   count_zero;

  assign take       = in_valid_i & ~in_stall_o;
  assign count_zero = (count == '0);

  lcm_gate #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_gate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .kind_i        (kind_i),
    .zero_button_i (zero_button_i),
    .gate_ticks_i  (gate_ticks_q),
    .evt_o         (gate_evt),
    .count_o       (count)
  );

  // Divider for scale / count^2.
  logic               div_start;
  div_status_t        div_status;
  logic [SCALE_W-1:0] div_quot;
  logic [SQ_W-1:0]    square_q;

  lcm_divider #(
    .NUM_W (SCALE_W),
    .DEN_W (SQ_W)
  ) u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (scale_q),
    .den_i    (square_q),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  // Sequencer.
  seq_state_e state_q, state_d;
  logic       emit_ok;
  logic       out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (gate_evt.close) state_d = S_SQUARE;
      S_SQUARE: state_d = S_LAUNCH;
      S_LAUNCH: state_d = count_zero ? S_DIFF : S_DIVIDE;
      S_DIVIDE: if (div_status.done) state_d = S_DIFF;
      S_DIFF:   state_d = S_EMIT;
      S_EMIT:   if (emit_ok) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    emit_ok    = 1'b0;
    unique case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_LAUNCH: div_start  = ~count_zero;
      S_EMIT:   emit_ok    = ~out_valid_q | ~out_stall_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Calculation datapath.
  logic               zero_q;
  logic [SCALE_W-1:0] raw_q, diff_q, offset_q;
  logic [SCALE_W:0]   raw_minus_off;

  assign raw_minus_off = {1'b0, raw_q} - {1'b0, offset_q};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE:   if (gate_evt.close) zero_q <= gate_evt.zero;
      S_SQUARE: square_q <= SQ_W'(count) * SQ_W'(count);
      S_LAUNCH: if (count_zero) raw_q <= RAW_SAT;
      S_DIVIDE: if (div_status.done) raw_q <= div_quot;
      S_DIFF: begin
        // Absolute difference; a borrow means the offset is the larger.
        diff_q <= raw_minus_off[SCALE_W] ? (offset_q - raw_q)
                                         : raw_minus_off[SCALE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // The zero offset is architectural state and so is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (state_q == S_DIFF && zero_q) begin
      offset_q <= raw_q;
    end
  end

  // Output register.
  logic [READ_W-1:0] reading_q;
  status_e           status_q;
  logic [EDGE_W-1:0] edge_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      edge_count_q <= EDGE_W'(count);
      if (zero_q) begin
        status_q  <= STATUS_ZERO_SET;
        reading_q <= '0;
      end else if (count_zero || diff_q > SCALE_W'(range_q)) begin
        status_q  <= STATUS_RANGE_ERR;
        reading_q <= '0;
      end else begin
        status_q  <= STATUS_VALID;
        reading_q <= diff_q[READ_W-1:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reading_o    = reading_q;
  assign status_o     = status_q;
  assign edge_count_o = edge_count_q;

  // Assertions.
  a_error_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_VALID) |-> reading_o == '0)
    else $error("non-valid status carries a non-zero reading");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  a_leave_idle_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (state_d != S_IDLE) |-> gate_evt.close)
    else $error("calculation started without the gate closing");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result appeared outside the emit step");

  a_offset_only_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(offset_q) |-> $past(state_q) == S_DIFF && $past(zero_q))
    else $error("zero offset changed without a zero request");

endmodule

// ----- tb/lc_meter_gated_counter_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc_meter_gated_counter_core_test: self-checking bench for the gated counter
// Drives start, tick and edge items into the core under random idling and
// back-pressure. An item-level model of the gate and the reading arithmetic
// predicts every result, and each result transfer is checked field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lc_meter_gated_counter_core_test;
  import lcm_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  // A margin for the block to settle after the last reading owed has been
  // taken, before a register is touched.
  localparam int unsigned QUIET_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned ROUND_ITEMS  = 30;
  // The kind field has one code with no meaning; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [63:0] RAW_SAT_64 = {{(64-SCALE_W){1'b0}}, RAW_SAT};

  typedef struct packed {
    logic [READ_W-1:0] reading;
    status_e           status;
    logic [EDGE_W-1:0] edge_count;
  } meter_result_t;

  // Clock, reset and the signals that face the block.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = KIND_START;
  logic                 zero_button = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [READ_W-1:0]    reading;
  logic [STATUS_W-1:0]  status;
  logic [EDGE_W-1:0]    edge_count;

  // Shadow copy of the configuration and of the measurement state.
  logic [GATE_W-1:0]  m_gate_ticks = GATE_TICKS_RST;
  logic [SCALE_W-1:0] m_scale      = SCALE_RST;
  logic [RANGE_W-1:0] m_range      = RANGE_RST;
  logic               m_gate_open  = 1'b0;
  logic [GATE_W-1:0]  m_ticks      = '0;
  logic [EDGE_W-1:0]  m_edges      = '0;
  logic [SCALE_W-1:0] m_offset     = '0;

  // Readings still owed by the block, oldest first.
  meter_result_t readings_due[$];
  meter_result_t due_now;

  int unsigned items_counted = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  lc_meter_gated_counter_core #(
    .COUNT_WIDTH(COUNT_WIDTH_DEF)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .zero_button_i(zero_button),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .reading_o    (reading),
    .status_o     (status),
    .edge_count_o (edge_count)
  );

  always #4 clk = ~clk;

  // The closing tick turns the edge count into a reading. With no edges the
  // raw value saturates to the all-ones 53-bit value; otherwise it is the
  // truncated quotient of the scale by the exact square of the count.
  function automatic meter_result_t close_gate(logic zero_pressed);
    logic [63:0] count;
    logic [63:0] raw;
    logic [63:0] offset;
    logic [63:0] diff;
    meter_result_t r;
    count = {32'd0, m_edges};
    offset = {{(64-SCALE_W){1'b0}}, m_offset};
    if (count == 64'd0) begin
      raw = RAW_SAT_64;
    end else begin
      raw = {{(64-SCALE_W){1'b0}}, m_scale} / (count * count);
    end
    r.reading = '0;
    r.edge_count = m_edges;
    if (zero_pressed) begin
      // The zero button stores the raw value and reports a zero reading with the zero-set status.
      m_offset = raw[SCALE_W-1:0];
      r.status = STATUS_ZERO_SET;
    end else begin
      diff = (raw >= offset) ? raw - offset : offset - raw;
      if (count == 64'd0 || diff > {32'd0, m_range}) begin
        r.status = STATUS_RANGE_ERR;
      end else begin
        r.status = STATUS_VALID;
        r.reading = diff[READ_W-1:0];
      end
    end
    return r;
  endfunction

  // Advances the model by one accepted item and queues any reading it causes.
  // Returns zero for items that the block simply ignores.
  function automatic bit predict_item(logic [KIND_W-1:0] k, logic zero_pressed);
    if (k == KIND_START) begin
      // A start always clears the counters, even in the middle of a gate.
      m_ticks = '0;
      m_edges = '0;
      m_gate_open = 1'b1;
      return 1'b1;
    end
    if (!m_gate_open || k == KIND_SPARE) begin
      return 1'b0;
    end
    if (k == KIND_EDGE) begin
      m_edges = m_edges + EDGE_W'(1);
      return 1'b1;
    end
    // A gate length of zero behaves like one: the first tick closes it.
    if ({1'b0, m_ticks} + 9'd1 >= {1'b0, m_gate_ticks}) begin
      m_gate_open = 1'b0;
      readings_due.push_back(close_gate(zero_pressed));
    end else begin
      m_ticks = m_ticks + GATE_W'(1);
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // Offers one item and waits for its transfer. Valid is only ever lowered
  // during an idle gap, so an item that follows straight on keeps it high.
  task automatic send_item(logic [KIND_W-1:0] k, logic zero_pressed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    zero_button <= zero_pressed;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    if (predict_item(k, zero_pressed)) begin
      items_counted++;
    end
  endtask

  // Stops offering items until every reading owed has been transferred, then
  // lets the block settle so that a register write cannot meet a busy core.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_e idx, logic [CFG_DAT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GATE_TICKS: m_gate_ticks = value[GATE_W-1:0];
      CFG_SCALE:      m_scale = value;
      CFG_RANGE:      m_range = value[RANGE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [GATE_W-1:0] gate, logic [SCALE_W-1:0] scale,
                            logic [RANGE_W-1:0] limit);
    wait_idle();
    write_register(CFG_GATE_TICKS, {{(CFG_DAT_W-GATE_W){1'b0}}, gate});
    write_register(CFG_SCALE, scale);
    write_register(CFG_RANGE, {{(CFG_DAT_W-RANGE_W){1'b0}}, limit});
  endtask

  // One well-formed gate: a start, then the configured number of ticks with
  // the requested number of edges spread at random between them.
  task automatic run_measurement(int unsigned edges_total, logic zero_on_close);
    int unsigned n_ticks;
    int unsigned left;
    int unsigned burst;
    n_ticks = (m_gate_ticks == '0) ? 1 : m_gate_ticks;
    left = edges_total;
    send_item(KIND_START, 1'($urandom_range(1)));
    for (int unsigned t = 1; t <= n_ticks; t++) begin
      burst = (t == n_ticks) ? left : $urandom_range(left);
      left -= burst;
      repeat (burst) send_item(KIND_EDGE, 1'($urandom_range(1)));
      send_item(KIND_TICK, (t == n_ticks) ? zero_on_close : 1'($urandom_range(1)));
    end
  endtask

  // The reset values of the registers are checked first, before any write:
  // a zero set followed by the same count must read back as zero.
  task automatic test_reset_defaults();
    run_measurement(25, 1'b1);
    run_measurement(25, 1'b0);
    run_measurement(24, 1'b0);
  endtask

  // Short directed sequences for the corner behaviours of the gate logic.
  task automatic test_special_cases();
    set_config(8'd0, SCALE_RST, RANGE_RST);
    // Ticks, edges and the spare code are ignored while the gate is shut.
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_EDGE, 1'b0);
    send_item(KIND_SPARE, 1'b1);
    // No edges at all: the zero set stores the saturated value, and a plain
    // measurement with no edges reports a range error.
    send_item(KIND_START, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_START, 1'b0);
    send_item(KIND_TICK, 1'b0);
    // A start in the middle of a gate throws the earlier edges away.
    send_item(KIND_START, 1'b0);
    send_item(KIND_EDGE, 1'b0);
    send_item(KIND_EDGE, 1'b1);
    send_item(KIND_START, 1'b1);
    send_item(KIND_EDGE, 1'b0);
    send_item(KIND_SPARE, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_START, 1'b0);
    send_item(KIND_EDGE, 1'b1);
    send_item(KIND_TICK, 1'b0);
    // The range limit itself is still a valid reading, one above it is not.
    // With scale 1000 an offset taken at a count of 10 is 10, and a count of 1 gives
    // a difference of exactly 990.
    set_config(8'd1, 53'd1000, 32'd990);
    run_measurement(10, 1'b1);
    run_measurement(1, 1'b0);
    set_config(8'd1, 53'd1000, 32'd989);
    run_measurement(1, 1'b0);
  endtask

  // The extremes of every register.
  task automatic test_config_extremes();
    set_config(8'd255, RAW_SAT, 32'hFFFF_FFFF);
    run_measurement(20, 1'b0);
    set_config(8'd1, 53'd0, 32'd0);
    run_measurement(5, 1'b1);
    run_measurement(0, 1'b0);
    run_measurement(7, 1'b0);
    set_config(8'd2, RAW_SAT, 32'd0);
    run_measurement(1, 1'b1);
    run_measurement(1, 1'b0);
    run_measurement(0, 1'b0);
  endtask

  // The receiver holds off for a long stretch while single-tick gates keep
  // arriving, so the output register fills and the input must stall.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(8'd1, 53'd4000000, 32'hFFFF_FFFF);
    hold_request = 400;
    repeat (6) run_measurement($urandom_range(1, 5), 1'($urandom_range(1)));
    wait_idle();
  endtask

  // Random rounds, each with fresh register values. Most of the traffic is
  // whole gates, mostly with edge counts clustered round a reference, so that
  // a zero set followed by nearby counts gives in-range readings; the rest is
  // stray items that break gates open or close them early.
  task automatic test_random_phase(int unsigned sender_idle, int unsigned receiver_stall,
                                   int unsigned quota);
    int unsigned stop_at;
    int unsigned round_end;
    int unsigned ref_edges;
    int unsigned pick;
    int unsigned n_edges;
    int unsigned scale_bits;
    logic [63:0] wide;
    logic [RANGE_W-1:0] limit;
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    stop_at = items_counted + quota;
    while (items_counted < stop_at) begin
      scale_bits = $urandom_range(8, SCALE_W);
      wide = {$urandom, $urandom};
      wide = wide >> (64 - scale_bits);
      case ($urandom_range(3))
        0:       limit = '1;
        1:       limit = $urandom;
        2:       limit = $urandom_range(1000);
        default: limit = $urandom_range(1000000);
      endcase
      set_config(GATE_W'($urandom_range(4)), wide[SCALE_W-1:0], limit);
      ref_edges = $urandom_range(2, 20);
      round_end = items_counted + ROUND_ITEMS;
      if (round_end > stop_at) begin
        round_end = stop_at;
      end
      while (items_counted < round_end) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          send_item(KIND_W'($urandom_range(3)), 1'($urandom_range(1)));
        end else begin
          if (pick < 20) begin
            n_edges = 0;
          end else if (pick < 36) begin
            n_edges = $urandom_range(120);
          end else begin
            n_edges = ref_edges - 1 + $urandom_range(2);
          end
          run_measurement(n_edges, $urandom_range(99) < 20);
        end
      end
    end
  endtask

  // Receiver: a long hold when one is asked for, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every result transfer is matched against the oldest reading owed.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (readings_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: reading %0d status %0d edges %0d",
                                reading, status, edge_count));
      end else begin
        due_now = readings_due.pop_front();
        if (reading !== due_now.reading || status !== due_now.status ||
            edge_count !== due_now.edge_count) begin
          note_mismatch($sformatf(
            "result mismatch: expected reading %0d status %0d edges %0d, got %0d %0d %0d",
            due_now.reading, due_now.status, due_now.edge_count,
            reading, status, edge_count));
        end
      end
    end
  end

  // Watchdog against a block that stops answering.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_back_pressure();
    test_random_phase(36, 55, 70);
    test_random_phase(55, 36, 70);
    test_random_phase(0, 0, 70);
    wait_idle();
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
